// ===== hw/rtl/source_text_tokenizer_assert.svh =====
// Assertion macros used by the tokenizer checker.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// Clocked check, masked while reset is high.
`define STT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define STT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/stt_pkg.sv =====
package stt_pkg;

  // scanner modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NUM  = 2'd1;
  localparam logic [1:0] MODE_WORD = 2'd2;
  localparam logic [1:0] MODE_SYM  = 2'd3;

  // token kinds
  localparam logic [5:0] KIND_EOF       = 6'd0;
  localparam logic [5:0] KIND_ERROR     = 6'd1;
  localparam logic [5:0] KIND_ID        = 6'd2;
  localparam logic [5:0] KIND_NUM       = 6'd3;
  localparam logic [5:0] KIND_NOT       = 6'd24;
  localparam logic [5:0] KIND_SINGLE    = 6'd25;
  localparam logic [5:0] KIND_PAIR      = 6'd44;
  localparam logic [5:0] KIND_PAIR_LAST = 6'd54;
  // pair lookup result when two bytes form no operator
  localparam logic [5:0] PAIR_NONE      = 6'd0;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  // keyword table: text right-aligned, first byte highest
  localparam int KW_MAX_LEN = 8;
  localparam int KW_COUNT   = 29;

  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    "i16", "int16", "i32", "int32", "I64", "int64", "u16", "uint16",
    "u32", "uint32", "u64", "uint64", "f32", "float32", "f64", "float64",
    "public", "private", "void", "if", "else", "while", "for", "switch",
    "class", "return", "continue", "break", "not"
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd3, 4'd5, 4'd3, 4'd5, 4'd3, 4'd6,
    4'd3, 4'd6, 4'd3, 4'd6, 4'd3, 4'd7, 4'd3, 4'd7,
    4'd6, 4'd7, 4'd4, 4'd2, 4'd4, 4'd5, 4'd3, 4'd6,
    4'd5, 4'd6, 4'd8, 4'd5, 4'd3
  };

  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    6'd4, 6'd4, 6'd5, 6'd5, 6'd6, 6'd6, 6'd7, 6'd7,
    6'd8, 6'd8, 6'd9, 6'd9, 6'd10, 6'd10, 6'd11, 6'd11,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19,
    6'd20, 6'd21, 6'd22, 6'd23, KIND_NOT
  };

  // token queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  // up to two tokens written into the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  // character classes
  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c inside {[8'd9:8'd13]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return is_alpha(c) || (c == "_");
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_") || (c == "'");
  endfunction

  // bytes that may open a two-byte operator
  function automatic logic is_prefix(input logic [7:0] c);
    return c inside {"=", "!", "<", ">", "&", "|", "-", "+", "*", "/"};
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "!":     k = KIND_NOT;
      ")":     k = KIND_SINGLE;
      "(":     k = KIND_SINGLE + 6'd1;
      "}":     k = KIND_SINGLE + 6'd2;
      "{":     k = KIND_SINGLE + 6'd3;
      ",":     k = KIND_SINGLE + 6'd4;
      ";":     k = KIND_SINGLE + 6'd5;
      ":":     k = KIND_SINGLE + 6'd6;
      ".":     k = KIND_SINGLE + 6'd7;
      "+":     k = KIND_SINGLE + 6'd8;
      "-":     k = KIND_SINGLE + 6'd9;
      "/":     k = KIND_SINGLE + 6'd10;
      "*":     k = KIND_SINGLE + 6'd11;
      "^":     k = KIND_SINGLE + 6'd12;
      "]":     k = KIND_SINGLE + 6'd13;
      "[":     k = KIND_SINGLE + 6'd14;
      "=":     k = KIND_SINGLE + 6'd15;
      ">":     k = KIND_SINGLE + 6'd16;
      "<":     k = KIND_SINGLE + 6'd17;
      "@":     k = KIND_SINGLE + 6'd18;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] k;
    case ({a, b})
      "==":    k = KIND_PAIR;
      "!=":    k = KIND_PAIR + 6'd1;
      "<=":    k = KIND_PAIR + 6'd2;
      ">=":    k = KIND_PAIR + 6'd3;
      "&&":    k = KIND_PAIR + 6'd4;
      "||":    k = KIND_PAIR + 6'd5;
      "->":    k = KIND_PAIR + 6'd6;
      "+=":    k = KIND_PAIR + 6'd7;
      "*=":    k = KIND_PAIR + 6'd8;
      "/=":    k = KIND_PAIR + 6'd9;
      "-=":    k = KIND_PAIR + 6'd10;
      default: k = PAIR_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/stt_kw_match.sv =====
// Keyword classifier for a finished word: all table entries compared in parallel.
module stt_kw_match import stt_pkg::*; (
  input  logic [KW_MAX_LEN-1:0][7:0] prefix,
  input  logic [15:0]                length,
  input  logic                       not_keyword,
  output logic [5:0]                 kind
);

  logic [63:0] word;

  // first byte of the word in the top byte, zero padded
  always_comb begin
    for (int j = 0; j < KW_MAX_LEN; j++) begin
      word[63 - 8 * j -: 8] = prefix[j];
    end
  end

  // entries are distinct, so at most one matches
  always_comb begin
    kind = KIND_ID;
    if (!not_keyword) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if ((length == 16'(KW_LEN[i])) &&
            (word == (KW_TEXT[i] << (8 * (KW_MAX_LEN - int'(KW_LEN[i])))))) begin
          kind = KW_KIND[i];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/stt_token_fifo.sv =====
// Small token queue: takes up to two tokens a cycle, hands out one.
module stt_token_fifo import stt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  output logic   room2,
  output token_t head,
  output logic   head_valid,
  input  logic   pop_ready
);

  token_t             entries [FIFO_DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;
  logic               pop;

  assign head       = entries[rptr];
  assign head_valid = (count != '0);
  assign pop        = head_valid && pop_ready;
  assign room2      = (count <= CNT_W'(FIFO_DEPTH - 2));

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push.count);
      rptr  <= rptr + PTR_W'(pop);
      count <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  // token storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wptr + PTR_W'(1)] <= push.second;
    end
  end

endmodule

// ===== hw/rtl/source_text_tokenizer.sv =====
// Source text tokenizer. Takes one byte word per cycle on the item channel
// (cmd 0 = byte in ch, cmd 1 = end of text) and returns tokens with kind,
// start offset and saturating length; the end-of-text word flushes the token
// in progress and gives an EOF token with is_last set, then offsets restart
// at zero. Each byte updates the scanner registers and writes
// zero, one or two tokens into a four-entry token queue; a token can be taken
// the cycle after the byte that closes it. item_ready is high while the
// queue has two free slots, so bytes go in at one per cycle for as long as
// tokens leave as fast as they are made. A byte that closes a pending token
// and is itself a one-byte token, or an end of text with a token pending,
// writes two tokens; a run of those is held to the output port's rate of one
// token per cycle.
module source_text_tokenizer import stt_pkg::*; #(
  parameter int KEYWORD_CHARS = 8,
  parameter int OFFSET_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        cmd,
  input  logic [7:0]  ch,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [5:0]  token_kind,
  output logic [31:0] token_start,
  output logic [15:0] token_length,
  output logic        is_last
);

  // scanner registers
  logic [1:0]                       mode, mode_next;
  logic [OFFSET_BITS-1:0]           byte_position, byte_position_next;
  logic [OFFSET_BITS-1:0]           pending_start, pending_start_next;
  logic [15:0]                      pending_length, pending_length_next;
  logic                             dot_seen, dot_seen_next;
  logic [KEYWORD_CHARS-1:0][7:0]    word_prefix, word_prefix_next;
  logic                             word_not_keyword, word_not_keyword_next;
  logic [7:0]                       pending_symbol, pending_symbol_next;

  logic       accept;
  logic       do_start;
  logic [5:0] word_kind;
  logic [5:0] pk;
  token_t     flush_tok;
  logic       flush_vld;
  token_t     tok_a, tok_b;
  logic       a_vld, b_vld;
  push_t      push;
  token_t     head;

  assign accept = item_valid && item_ready;
  assign pk     = pair_kind(pending_symbol, ch);

  stt_kw_match u_kw_match (
    .prefix      (word_prefix[KW_MAX_LEN-1:0]),
    .length      (pending_length),
    .not_keyword (word_not_keyword),
    .kind        (word_kind)
  );

  // token closed by leaving the current mode
  always_comb begin
    flush_tok.start  = 32'(pending_start);
    flush_tok.length = pending_length;
    flush_tok.last   = 1'b0;
    flush_vld        = 1'b1;
    case (mode)
      MODE_NUM:  flush_tok.kind = KIND_NUM;
      MODE_WORD: flush_tok.kind = word_kind;
      MODE_SYM: begin
        flush_tok.kind   = single_kind(pending_symbol);
        flush_tok.length = 16'd1;
      end
      default: begin
        flush_tok.kind = KIND_EOF;
        flush_vld      = 1'b0;
      end
    endcase
  end

  // next scanner state and tokens for the accepted word
  always_comb begin
    mode_next             = mode;
    byte_position_next    = byte_position;
    pending_start_next    = pending_start;
    pending_length_next   = pending_length;
    dot_seen_next         = dot_seen;
    word_prefix_next      = word_prefix;
    word_not_keyword_next = word_not_keyword;
    pending_symbol_next   = pending_symbol;
    do_start              = 1'b0;
    tok_a                 = flush_tok;
    a_vld                 = 1'b0;
    tok_b.kind            = single_kind(ch);
    tok_b.start           = 32'(byte_position);
    tok_b.length          = 16'd1;
    tok_b.last            = 1'b0;
    b_vld                 = 1'b0;

    if (accept) begin
      if (cmd) begin
        // end of text: flush, then EOF just past the last byte
        a_vld              = flush_vld;
        tok_b.kind         = KIND_EOF;
        tok_b.length       = 16'd0;
        tok_b.last         = 1'b1;
        b_vld              = 1'b1;
        mode_next          = MODE_IDLE;
        byte_position_next = '0;
      end else begin
        byte_position_next = byte_position + OFFSET_BITS'(1);
        case (mode)
          MODE_SYM: begin
            if (pk != PAIR_NONE) begin
              tok_a.kind   = pk;
              tok_a.length = 16'd2;
              a_vld        = 1'b1;
              mode_next    = MODE_IDLE;
            end else begin
              a_vld    = 1'b1;
              do_start = 1'b1;
            end
          end
          MODE_NUM: begin
            if (is_digit(ch) || ((ch == ".") && !dot_seen)) begin
              if (ch == ".") dot_seen_next = 1'b1;
              if (pending_length != LEN_MAX) pending_length_next = pending_length + 16'd1;
            end else begin
              a_vld    = 1'b1;
              do_start = 1'b1;
            end
          end
          MODE_WORD: begin
            if (is_word_char(ch)) begin
              for (int i = 0; i < KEYWORD_CHARS; i++) begin
                if (pending_length == 16'(i)) word_prefix_next[i] = ch;
              end
              if (pending_length >= 16'(KEYWORD_CHARS)) word_not_keyword_next = 1'b1;
              if (ch == "'") word_not_keyword_next = 1'b1;
              if (pending_length != LEN_MAX) pending_length_next = pending_length + 16'd1;
            end else begin
              a_vld    = 1'b1;
              do_start = 1'b1;
            end
          end
          default: do_start = 1'b1;
        endcase

        // open a new token, or emit a lone one at once
        if (do_start) begin
          mode_next = MODE_IDLE;
          if (is_space(ch)) begin
            mode_next = MODE_IDLE;
          end else if (is_prefix(ch)) begin
            mode_next           = MODE_SYM;
            pending_start_next  = byte_position;
            pending_symbol_next = ch;
          end else if (is_digit(ch)) begin
            mode_next           = MODE_NUM;
            pending_start_next  = byte_position;
            pending_length_next = 16'd1;
            dot_seen_next       = 1'b0;
          end else if (is_word_start(ch)) begin
            mode_next             = MODE_WORD;
            pending_start_next    = byte_position;
            pending_length_next   = 16'd1;
            word_prefix_next      = '0;
            word_prefix_next[0]   = ch;
            word_not_keyword_next = 1'b0;
          end else begin
            b_vld = 1'b1;
          end
        end
      end
    end
  end

  // pack the closed tokens in order
  always_comb begin
    push.second = tok_b;
    if (a_vld) begin
      push.first = tok_a;
      push.count = b_vld ? 2'd2 : 2'd1;
    end else begin
      push.first = tok_b;
      push.count = b_vld ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      byte_position <= '0;
    end else begin
      mode          <= mode_next;
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    pending_start    <= pending_start_next;
    pending_length   <= pending_length_next;
    dot_seen         <= dot_seen_next;
    word_prefix      <= word_prefix_next;
    word_not_keyword <= word_not_keyword_next;
    pending_symbol   <= pending_symbol_next;
  end

  stt_token_fifo u_token_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room2      (item_ready),
    .head       (head),
    .head_valid (token_valid),
    .pop_ready  (token_ready)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign is_last      = head.last;

endmodule

// ===== hw/rtl/stt_checker.sv =====
`include "source_text_tokenizer_assert.svh"

// Port-level checks on the token channel.
module stt_checker import stt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        token_valid,
  input logic        token_ready,
  input logic [5:0]  token_kind,
  input logic [31:0] token_start,
  input logic [15:0] token_length,
  input logic        is_last
);

  logic [54:0] token_word;
  logic        stalled;
  logic        eof_flag;
  logic        eof_ok;
  logic        pair_flag;
  logic        pair_ok;

  // token word as one vector, and the conditions the checks look at
  assign token_word = {token_kind, token_start, token_length, is_last};
  assign stalled    = token_valid && !token_ready;
  assign eof_flag   = token_valid && (is_last || (token_kind == KIND_EOF));
  assign eof_ok     = is_last && (token_kind == KIND_EOF) && (token_length == 16'd0);
  assign pair_flag  = token_valid && (token_kind >= KIND_PAIR);
  assign pair_ok    = (token_kind <= KIND_PAIR_LAST) && (token_length == 16'd2);

  // a stalled token word holds
  `STT_ASSERT(a_token_hold, stalled |=> token_valid && $stable(token_word), "token moved in stall")

  // EOF and is_last go together, with zero length
  `STT_ASSERT(a_eof_last, eof_flag |-> eof_ok, "EOF token malformed")

  // two-byte operators are two bytes long
  `STT_ASSERT(a_pair_len, pair_flag |-> pair_ok, "operator token length wrong")

  // queue is empty after reset
  `STT_ASSERT_ALWAYS(a_reset_empty, rst |=> !token_valid, "token shown right after reset")

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);
